>>> rtl/knnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnh_pkg
// Shared types, codes and helpers for the bounded max-heap unit.
// ----------------------------------------------------------------------------
package knnh_pkg;

  localparam int unsigned DIST_BITS  = 32;
  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned CFG_BITS   = 7;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_LARGEST = 2'd1,
    OP_DRAIN   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_LEVEL,
    ST_CMP,
    ST_LARG,
    ST_EMPTY,
    ST_DLOAD,
    ST_DWAIT,
    ST_DOUT
  } state_e;

  typedef struct packed {
    op_e                   operation;
    logic [9:0]            row;
    logic [DIST_BITS-1:0]  distance;
    logic [INDEX_BITS-1:0] point_index;
  } in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]  distance_out;
    logic [INDEX_BITS-1:0] index_out;
    logic                  slot_valid;
    logic                  last;
  } out_t;

  // One heap slot as it is kept in memory.
  typedef struct packed {
    logic                  valid;
    logic [DIST_BITS-1:0]  distance;
    logic [INDEX_BITS-1:0] index;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, distance: '1, index: '0};

  // True if slot a is emitted before slot b when a row is drained.
  function automatic logic sorts_before(input entry_t a, input entry_t b);
    logic r;
    if (a.distance != b.distance) begin
      r = a.distance < b.distance;
    end else if (a.valid != b.valid) begin
      r = a.valid;
    end else begin
      r = a.index < b.index;
    end
    return r;
  endfunction

endpackage

>>> rtl/knnh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnh_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module knnh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Reads return the old contents when the same entry is written.
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

>>> rtl/knnh_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnh_sorter
// Insertion sort register row: entries go in one a cycle, leave from the head.
// ----------------------------------------------------------------------------
module knnh_sorter #(
  parameter int unsigned K = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            ins_i,
  input  knnh_pkg::entry_t ins_entry_i,
  input  logic            pop_i,
  output knnh_pkg::entry_t head_o
);

  localparam int unsigned CNT_W = $clog2(K + 1);

  knnh_pkg::entry_t sort_q [K];
  knnh_pkg::entry_t sort_d [K];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [K-1:0]     lt;

  // Each cell compares the new entry with its own content.
  always_comb begin
    for (int j = 0; j < K; j++) begin
      lt[j] = (CNT_W'(j) < cnt_q) && knnh_pkg::sorts_before(ins_entry_i, sort_q[j]);
    end
  end

  // Cells after the insertion point take their left neighbor; the
  // first cell whose left neighbor stays put takes the new entry.
  always_comb begin
    cnt_d = cnt_q;
    for (int j = 0; j < K; j++) begin
      sort_d[j] = sort_q[j];
    end
    if (clr_i) begin
      cnt_d = '0;
    end else if (ins_i) begin
      cnt_d = cnt_q + 1'b1;
      for (int j = 0; j < K; j++) begin
        if (lt[j] || (CNT_W'(j) == cnt_q)) begin
          if ((j > 0) && lt[(j == 0) ? 0 : j - 1]) begin
            sort_d[j] = sort_q[(j == 0) ? 0 : j - 1];
          end else begin
            sort_d[j] = ins_entry_i;
          end
        end
      end
    end else if (pop_i) begin
      for (int j = 0; j < K - 1; j++) begin
        sort_d[j] = sort_q[j + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < K; j++) begin
      sort_q[j] <= sort_d[j];
    end
  end

  assign head_o = sort_q[0];

endmodule

>>> rtl/knn_bounded_max_heap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_bounded_max_heap_unit
// Per-row bounded max-heaps of the k nearest candidates, kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_i, in_stall_o) carries one transaction
// per operation: push a candidate into a row, ask for the row's largest kept
// distance, or drain the row in ascending order. The output channel
// (out_valid_o, out_o, out_stall_i) returns one transaction per reply; the
// final transaction of a drain and every largest reply carry last.
// The block works on one transaction at a time. A push first checks the root,
// then descends one heap level at a time until it stops or reaches a leaf;
// each level reads both children from the two RAM read ports and writes back
// one slot. A drain sweeps all K slots of the row (clearing one slot per
// cycle and reading the slots in use into an insertion-sort register row),
// then emits its k_in_use results one per cycle while the receiver does not
// stall.
// After reset the RAM is swept to the empty state, one entry a cycle, over all
// of its ROWS * 2^ceil(log2 K) entries (16384 at the defaults); in_stall_o stays
// high during the sweep while configuration writes are still taken.
// A stalled receiver holds the output register and, in turn, the sequence
// that produces the next reply; no reply is ever lost or repeated.
// ----------------------------------------------------------------------------
module knn_bounded_max_heap_unit #(
  parameter int unsigned ROWS = 1024,
  parameter int unsigned K    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  knnh_pkg::in_t                     in_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output knnh_pkg::out_t                    out_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_we_i,
  input  logic [knnh_pkg::CFG_BITS-1:0]     cfg_wdata_i
);

  // Slots of a row sit at a power-of-two stride so a RAM address is {row, slot}.
  localparam int unsigned SLOT_W = (K > 1) ? $clog2(K) : 1;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned ADDR_W = ROW_W + SLOT_W;
  localparam int unsigned DEPTH  = ROWS * (2 ** SLOT_W);
  localparam int unsigned CNT_W  = $clog2(K + 1);
  localparam int unsigned NODE_W = SLOT_W + 2;

  knnh_pkg::state_e state_q, state_d;

  logic [knnh_pkg::CFG_BITS-1:0] k_q;
  logic [CNT_W-1:0]              size_c;

  logic [ROW_W-1:0]  row_q, row_d;
  knnh_pkg::entry_t  new_q, new_d;
  logic [SLOT_W-1:0] node_q, node_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              rd_pend_q, rd_pend_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic              out_valid_q, out_valid_d;
  knnh_pkg::out_t    out_q, out_d;
  logic              out_free, out_load;

  logic              accept;
  logic [31:0]       row_wide;
  logic              row_ok;
  logic [ROW_W-1:0]  row_idx;

  logic [NODE_W-1:0] c1, c2;
  logic              has1, has2;
  logic              move;
  logic [SLOT_W-1:0] sw_slot;
  knnh_pkg::entry_t  sw_entry;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  knnh_pkg::entry_t  ram_wdata;
  logic              ram_re_a, ram_re_b;
  logic [ADDR_W-1:0] ram_raddr_a, ram_raddr_b;
  knnh_pkg::entry_t  rd_a, rd_b;

  logic              srt_clr, srt_pop;
  knnh_pkg::entry_t  srt_head;
  logic              drain_last;

  // Slot count in use, saturated to 1..K.
  always_comb begin
    if (k_q == '0) begin
      size_c = CNT_W'(1);
    end else if (k_q > knnh_pkg::CFG_BITS'(K)) begin
      size_c = CNT_W'(K);
    end else begin
      size_c = CNT_W'(k_q);
    end
  end

  assign in_stall_o = (state_q != knnh_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign row_wide   = 32'(in_i.row);
  assign row_ok     = row_wide < 32'(ROWS);
  assign row_idx    = row_wide[ROW_W-1:0];

  assign out_free   = !out_valid_q || !out_stall_i;

  // Children of the current sift node.
  assign c1   = NODE_W'({node_q, 1'b0}) + NODE_W'(1);
  assign c2   = c1 + NODE_W'(1);
  assign has1 = c1 < NODE_W'(size_c);
  assign has2 = c2 < NODE_W'(size_c);

  // Child choice: with one child it moves up if larger than the new entry;
  // with two the larger (first on a tie) moves up if the new entry is smaller.
  always_comb begin
    move     = 1'b0;
    sw_slot  = c1[SLOT_W-1:0];
    sw_entry = rd_a;
    if (!has2) begin
      move = rd_a.distance > new_q.distance;
    end else if (rd_a.distance >= rd_b.distance) begin
      move = new_q.distance < rd_a.distance;
    end else begin
      move     = new_q.distance < rd_b.distance;
      sw_slot  = c2[SLOT_W-1:0];
      sw_entry = rd_b;
    end
  end

  assign drain_last = (ptr_q == size_c - CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      knnh_pkg::ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = knnh_pkg::ST_IDLE;
      end
      knnh_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_i.operation)
            knnh_pkg::OP_PUSH:    if (row_ok) state_d = knnh_pkg::ST_ROOT;
            knnh_pkg::OP_LARGEST: state_d = row_ok ? knnh_pkg::ST_LARG : knnh_pkg::ST_EMPTY;
            knnh_pkg::OP_DRAIN:   state_d = row_ok ? knnh_pkg::ST_DLOAD : knnh_pkg::ST_EMPTY;
            default:              state_d = knnh_pkg::ST_IDLE;
          endcase
        end
      end
      knnh_pkg::ST_ROOT: begin
        state_d = (new_q.distance > rd_a.distance) ? knnh_pkg::ST_IDLE : knnh_pkg::ST_LEVEL;
      end
      knnh_pkg::ST_LEVEL: begin
        state_d = has1 ? knnh_pkg::ST_CMP : knnh_pkg::ST_IDLE;
      end
      knnh_pkg::ST_CMP: begin
        state_d = move ? knnh_pkg::ST_LEVEL : knnh_pkg::ST_IDLE;
      end
      knnh_pkg::ST_LARG, knnh_pkg::ST_EMPTY: begin
        if (out_free) state_d = knnh_pkg::ST_IDLE;
      end
      knnh_pkg::ST_DLOAD: begin
        if (scan_q == CNT_W'(K - 1)) state_d = knnh_pkg::ST_DWAIT;
      end
      knnh_pkg::ST_DWAIT: begin
        state_d = knnh_pkg::ST_DOUT;
      end
      knnh_pkg::ST_DOUT: begin
        if (out_free && drain_last) state_d = knnh_pkg::ST_IDLE;
      end
      default: state_d = knnh_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory and output controls.
  always_comb begin
    row_d       = row_q;
    new_d       = new_q;
    node_d      = node_q;
    scan_d      = scan_q;
    ptr_d       = ptr_q;
    clr_d       = clr_q;
    rd_pend_d   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {row_q, node_q};
    ram_wdata   = new_q;
    ram_re_a    = 1'b0;
    ram_re_b    = 1'b0;
    ram_raddr_a = {row_q, c1[SLOT_W-1:0]};
    ram_raddr_b = {row_q, c2[SLOT_W-1:0]};
    srt_clr     = 1'b0;
    srt_pop     = 1'b0;
    out_load    = 1'b0;
    out_d       = out_q;
    case (state_q)
      knnh_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = knnh_pkg::EMPTY_ENTRY;
        clr_d     = clr_q + ADDR_W'(1);
      end
      knnh_pkg::ST_IDLE: begin
        row_d       = row_idx;
        new_d       = '{valid: 1'b1, distance: in_i.distance, index: in_i.point_index};
        node_d      = '0;
        scan_d      = '0;
        ram_raddr_a = {row_idx, SLOT_W'(0)};
        if (accept && row_ok) begin
          case (in_i.operation)
            knnh_pkg::OP_PUSH, knnh_pkg::OP_LARGEST: ram_re_a = 1'b1;
            knnh_pkg::OP_DRAIN:                      srt_clr  = 1'b1;
            default:                                 ram_re_a = 1'b0;
          endcase
        end
      end
      knnh_pkg::ST_LEVEL: begin
        if (has1) begin
          ram_re_a = 1'b1;
          ram_re_b = 1'b1;
        end else begin
          ram_we = 1'b1;
        end
      end
      knnh_pkg::ST_CMP: begin
        ram_we = 1'b1;
        if (move) begin
          ram_wdata = sw_entry;
          node_d    = sw_slot;
        end
      end
      knnh_pkg::ST_LARG: begin
        out_load = out_free;
        out_d    = '{distance_out: rd_a.distance, index_out: rd_a.index,
                     slot_valid: rd_a.valid, last: 1'b1};
      end
      knnh_pkg::ST_EMPTY: begin
        out_load = out_free;
        out_d    = '{distance_out: '1, index_out: '0, slot_valid: 1'b0, last: 1'b1};
      end
      knnh_pkg::ST_DLOAD: begin
        // Read the slot for the sorter if it is in use, and clear it in the same cycle.
        ram_we      = 1'b1;
        ram_waddr   = {row_q, scan_q[SLOT_W-1:0]};
        ram_wdata   = knnh_pkg::EMPTY_ENTRY;
        ram_raddr_a = {row_q, scan_q[SLOT_W-1:0]};
        ram_re_a    = scan_q < size_c;
        rd_pend_d   = scan_q < size_c;
        scan_d      = scan_q + CNT_W'(1);
        ptr_d       = '0;
      end
      knnh_pkg::ST_DOUT: begin
        out_load = out_free;
        srt_pop  = out_free;
        out_d    = '{distance_out: srt_head.distance, index_out: srt_head.index,
                     slot_valid: srt_head.valid, last: drain_last};
        if (out_free) ptr_d = ptr_q + CNT_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knnh_pkg::ST_CLEAR;
      k_q         <= knnh_pkg::CFG_BITS'(16);
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      ptr_q       <= '0;
      node_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      ptr_q       <= ptr_d;
      node_q      <= node_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    new_q <= new_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  knnh_ram #(
    .WIDTH ($bits(knnh_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (ram_re_a),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rd_a),
    .re_b_i    (ram_re_b),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (rd_b)
  );

  knnh_sorter #(
    .K (K)
  ) u_sorter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (srt_clr),
    .ins_i       (rd_pend_q),
    .ins_entry_i (rd_a),
    .pop_i       (srt_pop),
    .head_o      (srt_head)
  );

endmodule
